// File: hdl/emr_pkg.sv
// Shared types and constants of the midpoint ellipse rasterizer.
// No dependencies; imported by emr_walk, emr_out and the top level.
package emr_pkg;

	// Width of the scaled decision variable (wraps modulo 2^32)
	localparam int DEC_BITS = 32;

	// Command codes of an input item
	localparam logic CMD_START = 1'b0;
	localparam logic CMD_STEP  = 1'b1;

	// Sequencer states, one-hot
	typedef enum logic [8:0] {
		S_IDLE = 9'b000000001,
		S_SQA  = 9'b000000010,
		S_SQB  = 9'b000000100,
		S_AB   = 9'b000001000,
		S_INIT = 9'b000010000,
		S_P1   = 9'b000100000,
		S_P2   = 9'b001000000,
		S_UPD  = 9'b010000000,
		S_EMIT = 9'b100000000
	} emr_state_t;

	// Request from the walk sequencer to the output stage
	typedef struct packed {
		logic load;
		logic last;
	} emr_emit_t;

endpackage

// File: hdl/emr_mul.sv
// Shared unsigned multiplier with a registered product.
// No dependencies; used by the walk sequencer for every product it needs.
module emr_mul #(
	parameter int A_BITS = 16,
	parameter int B_BITS = 11
) (
	input  logic                       clk,
	input  logic [A_BITS-1:0]          op_a,
	input  logic [B_BITS-1:0]          op_b,
	output logic [A_BITS+B_BITS-1:0]   prod_q
);

	// Register the product of whatever the sequencer presents
	always_ff @(posedge clk) begin
		prod_q <= (A_BITS + B_BITS)'(op_a) * (A_BITS + B_BITS)'(op_b);
	end

endmodule

// File: hdl/emr_walk.sv
// Walk sequencer: ellipse state, decision update and multiplier schedule.
// Depends on emr_pkg and emr_mul.
module emr_walk #(
	parameter int RADIUS_BITS = 8,
	parameter int COORD_BITS  = 10
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          cmd,
	input  logic signed [COORD_BITS-1:0]  center_x,
	input  logic signed [COORD_BITS-1:0]  center_y,
	input  logic [RADIUS_BITS-1:0]        radius_x,
	input  logic [RADIUS_BITS-1:0]        radius_y,
	input  logic                          out_free,
	output emr_pkg::emr_emit_t            emit,
	output logic signed [COORD_BITS-1:0]  cx_q,
	output logic signed [COORD_BITS-1:0]  cy_q,
	output logic [RADIUS_BITS+1:0]        x_q,
	output logic [RADIUS_BITS-1:0]        y_q
);
	import emr_pkg::*;

	localparam int X_BITS  = RADIUS_BITS + 2;
	localparam int SQ_BITS = 2 * RADIUS_BITS;
	localparam int MB_BITS = X_BITS + 1;
	localparam int PW      = SQ_BITS + MB_BITS;

	emr_state_t            state_q;
	logic [RADIUS_BITS-1:0] rad_a_q;
	logic [SQ_BITS-1:0]    a_sq_q;
	logic [SQ_BITS-1:0]    b_sq_q;
	logic [PW-1:0]         p1_q;
	logic [DEC_BITS-1:0]   dec_q;
	logic                  r2_q;
	logic                  active_q;
	logic                  last_q;

	logic [SQ_BITS-1:0]    op_a;
	logic [MB_BITS-1:0]    op_b;
	logic [PW-1:0]         prod;
	logic [MB_BITS-1:0]    y_dbl_m1;
	logic [MB_BITS-1:0]    x_p1;
	logic [DEC_BITS-1:0]   prod_d;
	logic [DEC_BITS-1:0]   p1_d;
	logic [DEC_BITS-1:0]   a_sq_d;
	logic [DEC_BITS-1:0]   b_sq_d;
	logic [DEC_BITS-1:0]   east_inc;
	logic [DEC_BITS-1:0]   dec_upd;
	logic [DEC_BITS-1:0]   dec_init;
	logic                  region_one;
	logic                  dec_neg;
	logic                  dec_pos;
	logic                  x_step;
	logic                  y_step;
	logic [RADIUS_BITS-1:0] y_next;

	emr_mul #(
		.A_BITS(SQ_BITS),
		.B_BITS(MB_BITS)
	) u_mul (
		.clk    (clk),
		.op_a   (op_a),
		.op_b   (op_b),
		.prod_q (prod)
	);

	// Operands derived from the current offsets
	assign y_dbl_m1 = MB_BITS'({y_q, 1'b0}) - MB_BITS'(1);
	assign x_p1     = MB_BITS'(x_q) + MB_BITS'(1);

	// Schedule the shared multiplier
	always_comb begin
		op_a = '0;
		op_b = '0;
		unique case (state_q)
			S_SQA: begin
				op_a = SQ_BITS'(rad_a_q);
				op_b = MB_BITS'(rad_a_q);
			end
			S_SQB: begin
				op_a = SQ_BITS'(y_q);
				op_b = MB_BITS'(y_q);
			end
			S_AB: begin
				op_a = a_sq_q;
				op_b = MB_BITS'(y_q);
			end
			S_P1: begin
				op_a = a_sq_q;
				op_b = y_dbl_m1;
			end
			S_P2: begin
				op_a = b_sq_q;
				op_b = x_p1;
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
	end

	// Decision terms, all taken modulo 2^DEC_BITS
	assign prod_d   = DEC_BITS'(prod);
	assign p1_d     = DEC_BITS'(p1_q);
	assign a_sq_d   = DEC_BITS'(a_sq_q);
	assign b_sq_d   = DEC_BITS'(b_sq_q);
	assign dec_neg  = dec_q[DEC_BITS-1];
	assign dec_pos  = !dec_neg && (dec_q != '0);
	assign dec_init = (b_sq_d << 2) - (prod_d << 2) + a_sq_d;

	// Region one holds while a^2*(2y-1) > 2*b^2*(x+1); prod carries b^2*(x+1) here
	assign region_one = !r2_q && ({1'b0, p1_q} > {prod, 1'b0});
	assign east_inc   = (prod_d << 3) + (b_sq_d << 2);

	// Pick the move and the decision increment for one step
	always_comb begin
		if (region_one) begin
			x_step = 1'b1;
			y_step = !dec_neg;
			if (dec_neg) begin
				dec_upd = dec_q + east_inc;
			end else begin
				dec_upd = dec_q + east_inc + (a_sq_d << 2) - (p1_d << 2);
			end
		end else begin
			x_step = !dec_pos;
			y_step = 1'b1;
			if (dec_pos) begin
				dec_upd = dec_q + (a_sq_d << 3) - (p1_d << 2);
			end else begin
				dec_upd = dec_q + (prod_d << 3) + (a_sq_d << 3) - (p1_d << 2);
			end
		end
	end

	assign y_next = y_q - RADIUS_BITS'(y_step);

	// Sequence one item and hold the ellipse state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			cx_q     <= '0;
			cy_q     <= '0;
			x_q      <= '0;
			y_q      <= '0;
			a_sq_q   <= '0;
			b_sq_q   <= '0;
			dec_q    <= '0;
			r2_q     <= 1'b0;
			active_q <= 1'b0;
			last_q   <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						if (cmd == CMD_START) begin
							cx_q    <= center_x;
							cy_q    <= center_y;
							y_q     <= radius_y;
							state_q <= S_SQA;
						end else if (active_q) begin
							state_q <= S_P1;
						end else begin
							last_q  <= 1'b1;
							state_q <= S_EMIT;
						end
					end
				end
				S_SQA: begin
					state_q <= S_SQB;
				end
				S_SQB: begin
					a_sq_q  <= prod[SQ_BITS-1:0];
					state_q <= S_AB;
				end
				S_AB: begin
					b_sq_q  <= prod[SQ_BITS-1:0];
					state_q <= S_INIT;
				end
				S_INIT: begin
					dec_q    <= dec_init;
					x_q      <= '0;
					r2_q     <= 1'b0;
					active_q <= (y_q != '0);
					last_q   <= (y_q == '0);
					state_q  <= S_EMIT;
				end
				S_P1: begin
					state_q <= S_P2;
				end
				S_P2: begin
					state_q <= S_UPD;
				end
				S_UPD: begin
					dec_q  <= dec_upd;
					x_q    <= x_q + X_BITS'(x_step);
					y_q    <= y_next;
					last_q <= (y_next == '0);
					if (!region_one) begin
						r2_q <= 1'b1;
					end
					if (y_next == '0) begin
						active_q <= 1'b0;
					end
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Capture the region-one product and the start radius
	always_ff @(posedge clk) begin
		if (state_q == S_P2) begin
			p1_q <= prod;
		end
		if (state_q == S_IDLE && in_valid && cmd == CMD_START) begin
			rad_a_q <= radius_x;
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign emit.load = (state_q == S_EMIT) && out_free;
	assign emit.last = last_q;

endmodule

// File: hdl/emr_out.sv
// Output stage: mirrors the offset into four points and holds the result item.
// Depends on emr_pkg.
module emr_out #(
	parameter int RADIUS_BITS = 8,
	parameter int COORD_BITS  = 10
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  emr_pkg::emr_emit_t            emit,
	input  logic signed [COORD_BITS-1:0]  cx,
	input  logic signed [COORD_BITS-1:0]  cy,
	input  logic [RADIUS_BITS+1:0]        ox,
	input  logic [RADIUS_BITS-1:0]        oy,
	output logic                          out_free,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [COORD_BITS:0]    p0_x,
	output logic signed [COORD_BITS:0]    p0_y,
	output logic signed [COORD_BITS:0]    p1_x,
	output logic signed [COORD_BITS:0]    p1_y,
	output logic signed [COORD_BITS:0]    p2_x,
	output logic signed [COORD_BITS:0]    p2_y,
	output logic signed [COORD_BITS:0]    p3_x,
	output logic signed [COORD_BITS:0]    p3_y,
	output logic                          last
);
	import emr_pkg::*;

	localparam int OUT_BITS = COORD_BITS + 1;
	localparam int X_BITS   = RADIUS_BITS + 2;
	localparam int SUM_W    = (OUT_BITS > X_BITS + 1) ? OUT_BITS : X_BITS + 1;

	logic [SUM_W-1:0]    cx_w;
	logic [SUM_W-1:0]    cy_w;
	logic [SUM_W-1:0]    ox_w;
	logic [SUM_W-1:0]    oy_w;
	logic [SUM_W-1:0]    xp;
	logic [SUM_W-1:0]    xm;
	logic [SUM_W-1:0]    yp;
	logic [SUM_W-1:0]    ym;
	logic                valid_q;
	logic                last_q;
	logic [OUT_BITS-1:0] xp_q;
	logic [OUT_BITS-1:0] xm_q;
	logic [OUT_BITS-1:0] yp_q;
	logic [OUT_BITS-1:0] ym_q;

	// Sign-extend the center, zero-extend the offsets, wrap to output width
	assign cx_w = SUM_W'(cx);
	assign cy_w = SUM_W'(cy);
	assign ox_w = SUM_W'(ox);
	assign oy_w = SUM_W'(oy);
	assign xp   = cx_w + ox_w;
	assign xm   = cx_w - ox_w;
	assign yp   = cy_w + oy_w;
	assign ym   = cy_w - oy_w;

	assign out_free = !valid_q || out_ready;

	// Hold the valid flag until the item is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (emit.load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	// Load the point set
	always_ff @(posedge clk) begin
		if (emit.load) begin
			xp_q   <= xp[OUT_BITS-1:0];
			xm_q   <= xm[OUT_BITS-1:0];
			yp_q   <= yp[OUT_BITS-1:0];
			ym_q   <= ym[OUT_BITS-1:0];
			last_q <= emit.last;
		end
	end

	assign out_valid = valid_q;
	assign p0_x      = xp_q;
	assign p0_y      = yp_q;
	assign p1_x      = xp_q;
	assign p1_y      = ym_q;
	assign p2_x      = xm_q;
	assign p2_y      = yp_q;
	assign p3_x      = xm_q;
	assign p3_y      = ym_q;
	assign last      = last_q;

endmodule

// File: hdl/midpoint_ellipse_raster.sv
// Midpoint ellipse rasterizer, top level.
// Depends on emr_pkg, emr_walk and emr_out.
//
// A start item (cmd 0) loads the center and radii and returns the four points at
// offset (0, radius_y); each step item (cmd 1) advances the quadrant walk by one
// move and returns the next four mirrored points, with last set on the final set.
// A step with no active ellipse returns the stored points again with last set.
// The block takes one item at a time and takes no new item before it has finished the
// last. A start item runs through the states SQA, SQB, AB, INIT and EMIT, a step item
// through P1, P2, UPD and EMIT, and a step while idle through EMIT alone; in_ready stays
// low until EMIT hands the result on. EMIT waits while the output register still holds
// a result that is not taken, so such a result holds off the next input item.
// The sequence comes from the single multiplier, which forms a^2, b^2 and a^2*b on
// start and a^2*(2y-1) and b^2*(x+1) on each step, one product per cycle.
module midpoint_ellipse_raster #(
	parameter int RADIUS_BITS = 8,
	parameter int COORD_BITS  = 10
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          cmd,
	input  logic signed [COORD_BITS-1:0]  center_x,
	input  logic signed [COORD_BITS-1:0]  center_y,
	input  logic [RADIUS_BITS-1:0]        radius_x,
	input  logic [RADIUS_BITS-1:0]        radius_y,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [COORD_BITS:0]    p0_x,
	output logic signed [COORD_BITS:0]    p0_y,
	output logic signed [COORD_BITS:0]    p1_x,
	output logic signed [COORD_BITS:0]    p1_y,
	output logic signed [COORD_BITS:0]    p2_x,
	output logic signed [COORD_BITS:0]    p2_y,
	output logic signed [COORD_BITS:0]    p3_x,
	output logic signed [COORD_BITS:0]    p3_y,
	output logic                          last
);
	import emr_pkg::*;

	emr_emit_t                    emit;
	logic                         out_free;
	logic signed [COORD_BITS-1:0] cx;
	logic signed [COORD_BITS-1:0] cy;
	logic [RADIUS_BITS+1:0]       ox;
	logic [RADIUS_BITS-1:0]       oy;

	emr_walk #(
		.RADIUS_BITS(RADIUS_BITS),
		.COORD_BITS (COORD_BITS)
	) u_walk (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.cmd      (cmd),
		.center_x (center_x),
		.center_y (center_y),
		.radius_x (radius_x),
		.radius_y (radius_y),
		.out_free (out_free),
		.emit     (emit),
		.cx_q     (cx),
		.cy_q     (cy),
		.x_q      (ox),
		.y_q      (oy)
	);

	emr_out #(
		.RADIUS_BITS(RADIUS_BITS),
		.COORD_BITS (COORD_BITS)
	) u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.emit      (emit),
		.cx        (cx),
		.cy        (cy),
		.ox        (ox),
		.oy        (oy),
		.out_free  (out_free),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.p0_x      (p0_x),
		.p0_y      (p0_y),
		.p1_x      (p1_x),
		.p1_y      (p1_y),
		.p2_x      (p2_x),
		.p2_y      (p2_y),
		.p3_x      (p3_x),
		.p3_y      (p3_y),
		.last      (last)
	);

endmodule

// File: hdl/emr_check.sv
// Port-level checks of the midpoint ellipse rasterizer, bound to its top level.
// Depends only on the top level's ports.
module emr_check #(
	parameter int COORD_BITS  = 10
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic signed [COORD_BITS:0]    p0_x,
	input logic signed [COORD_BITS:0]    p0_y,
	input logic signed [COORD_BITS:0]    p1_x,
	input logic signed [COORD_BITS:0]    p1_y,
	input logic signed [COORD_BITS:0]    p2_x,
	input logic signed [COORD_BITS:0]    p2_y,
	input logic signed [COORD_BITS:0]    p3_x,
	input logic signed [COORD_BITS:0]    p3_y,
	input logic                          last
);

	// A stalled result item holds its valid flag, points p0 and p3 and last
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(p0_x) && $stable(p0_y)
			&& $stable(p3_x) && $stable(p3_y) && $stable(last))
		else $error("result item changed while stalled");

	// The block works on one item at a time
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted back to back");

	// Finishing an item always leaves a result in the output register
	a_done_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(in_ready) |-> out_valid)
		else $error("item finished without a result");

	// Points mirror about the horizontal axis
	a_sym_x: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (p0_x == p1_x) && (p2_x == p3_x))
		else $error("x coordinates not mirrored");

	// Points mirror about the vertical axis
	a_sym_y: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (p0_y == p2_y) && (p1_y == p3_y))
		else $error("y coordinates not mirrored");

endmodule

bind midpoint_ellipse_raster emr_check #(
	.COORD_BITS (COORD_BITS)
) u_emr_check (.*);
